>>> hdl/wfe_pkg.sv
`default_nettype none

package wfe_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FRAC_BITS   = 8;
    localparam int LEN_W       = 7;
    localparam int MIN_WINDOW  = 2;
    localparam int MAX_WINDOW  = 64;
    localparam int DEF_WINDOW  = 20;

    localparam int SUM_W       = 23;
    localparam int ABS_W       = 22;
    localparam int SQ_W        = 37;
    localparam int PROD_W      = 43;
    localparam int NN_W        = 13;
    localparam int MEAN_DIV_W  = ABS_W + FRAC_BITS;
    localparam int VAR_DIV_W   = PROD_W + FRAC_BITS;
    localparam int ROOT_W      = 27;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int WORK_W      = RAD_W;
    localparam int REM_W       = 32;
    localparam int CNT_W       = 6;

    localparam int MEAN_W      = 24;
    localparam int VAR_W       = 39;
    localparam int ENERGY_W    = 37;
    localparam int MAG_W       = 27;
    localparam int WIN_W       = 16;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_of_series;
    } in_word_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_q8;
        logic [VAR_W-1:0]         variance_q8;
        logic [ENERGY_W-1:0]      energy;
        logic [MAG_W-1:0]         magnitude_q8;
        logic [WIN_W-1:0]         window_number;
    } out_word_t;

    typedef struct packed {
        logic              sqrt_mode;
        logic [REM_W-1:0]  rem;
        logic [1:0]        in_bits;
        logic [NN_W-1:0]   divisor;
        logic [ROOT_W-1:0] root;
    } step_req_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             qbit;
    } step_rsp_t;

endpackage

`default_nettype wire

>>> hdl/wfe_step_unit.sv
`default_nettype none

module wfe_step_unit
    import wfe_pkg::*;
(
    input  step_req_t req,
    output step_rsp_t rsp
);

    logic [REM_W-1:0] trial_val;
    logic [REM_W-1:0] subtrahend;
    logic [REM_W:0]   diff;

    always_comb begin
        if (req.sqrt_mode) begin
            trial_val  = {req.rem[REM_W-3:0], req.in_bits};
            subtrahend = {{(REM_W-ROOT_W-2){1'b0}}, req.root, 2'b01};
        end else begin
            trial_val  = {req.rem[REM_W-2:0], req.in_bits[1]};
            subtrahend = {{(REM_W-NN_W){1'b0}}, req.divisor};
        end
        diff     = {1'b0, trial_val} - {1'b0, subtrahend};
        rsp.qbit = ~diff[REM_W];
        rsp.rem  = rsp.qbit ? diff[REM_W-1:0] : trial_val;
    end

endmodule

`default_nettype wire

>>> hdl/window_feature_extractor.sv
// channel  | ports                       | word
// ---------+-----------------------------+---------------------------------
// input    | s_valid s_ready s_data      | sample, first_of_series
// result   | m_valid m_ready m_data      | mean, variance, energy, mag, index
// config   | cfg_wr_en cfg_wr_data       | window_len, no wait
//
// a word that does not close a window passes through accept and accumulate
// a closing word runs accept, accumulate, 3 setup, 30 + 51 division
// steps and 27 root steps on the one compare-subtract unit, then loads the result
// reset (aresetn low, synchronous) clears counters, sums and window_len to 20
// a closing word waits in its last step while the result register is full and m_ready is low

`default_nettype none

module window_feature_extractor
    import wfe_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [LEN_W-1:0] cfg_wr_data,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire in_word_t        s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output out_word_t            m_data
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_ACC      = 9'b000000010,
        ST_MUL_A    = 9'b000000100,
        ST_MUL_B    = 9'b000001000,
        ST_SUB      = 9'b000010000,
        ST_DIV_MEAN = 9'b000100000,
        ST_DIV_VAR  = 9'b001000000,
        ST_SQRT     = 9'b010000000,
        ST_FIN      = 9'b100000000
    } state_t;

    localparam logic [CNT_W-1:0] MEAN_LAST = CNT_W'(MEAN_DIV_W - 1);
    localparam logic [CNT_W-1:0] VAR_LAST  = CNT_W'(VAR_DIV_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

    state_t                     state_reg;
    logic [LEN_W-1:0]           window_len_reg;
    logic [LEN_W-1:0]           eff_len;
    logic [LEN_W-1:0]           fill_reg;
    logic [LEN_W-1:0]           fill_inc;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sumsq_reg;
    logic [WIN_W-1:0]           win_cnt_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [2*SAMPLE_W-1:0] x_sq;

    logic                       neg_reg;
    logic [ABS_W-1:0]           sum_abs_reg;
    logic [PROD_W-1:0]          prod_a_reg;
    logic [PROD_W-1:0]          prod_b_reg;
    logic [NN_W-1:0]            nn_reg;
    logic [SUM_W-1:0]           sum_neg;
    logic [LEN_W+SQ_W-1:0]      prod_a_full;
    logic [2*ABS_W-1:0]         prod_b_full;
    logic [2*LEN_W-1:0]         nn_full;

    logic [WORK_W-1:0]          work_reg;
    logic [WORK_W-1:0]          work_shift;
    logic [REM_W-1:0]           rem_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [MEAN_DIV_W-1:0]      mean_abs_reg;
    logic [MEAN_DIV_W-1:0]      mean_signed;
    logic [VAR_W-1:0]           var_reg;

    logic                       m_valid_reg;
    out_word_t                  m_data_reg;
    logic                       out_free;
    logic                       out_load;

    step_req_t                  step_req;
    step_rsp_t                  step_rsp;

    wfe_step_unit u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    always_comb begin
        if (window_len_reg < LEN_W'(MIN_WINDOW)) begin
            eff_len = LEN_W'(MIN_WINDOW);
        end else if (window_len_reg > LEN_W'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = window_len_reg;
        end
    end

    assign fill_inc    = fill_reg + LEN_W'(1);
    assign x_sq        = x_reg * x_reg;
    assign sum_neg     = -sum_reg;
    assign prod_a_full = fill_reg * sumsq_reg;
    assign prod_b_full = sum_abs_reg * sum_abs_reg;
    assign nn_full     = fill_reg * fill_reg;
    assign mean_signed = neg_reg ? (~mean_abs_reg + MEAN_DIV_W'(1)) : mean_abs_reg;
    assign out_free    = !m_valid_reg || m_ready;
    assign out_load    = (state_reg == ST_FIN) && out_free;

    always_comb begin
        step_req.sqrt_mode = (state_reg == ST_SQRT);
        step_req.rem       = rem_reg;
        step_req.in_bits   = work_reg[WORK_W-1 -: 2];
        step_req.divisor   = (state_reg == ST_DIV_VAR) ? nn_reg
                                                       : {{(NN_W-LEN_W){1'b0}}, fill_reg};
        step_req.root      = root_reg;
    end

    always_comb begin
        if (state_reg == ST_SQRT) begin
            work_shift = {work_reg[WORK_W-3:0], 2'b00};
        end else begin
            work_shift = {work_reg[WORK_W-2:0], step_rsp.qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= LEN_W'(DEF_WINDOW);
        end else if (cfg_wr_en) begin
            window_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            win_cnt_reg <= '0;
            cnt_reg     <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x_reg <= s_data.sample;
                        if (s_data.first_of_series) begin
                            fill_reg    <= '0;
                            sum_reg     <= '0;
                            sumsq_reg   <= '0;
                            win_cnt_reg <= '0;
                        end
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    sum_reg   <= sum_reg + SUM_W'(x_reg);
                    sumsq_reg <= sumsq_reg + {{(SQ_W-2*SAMPLE_W){1'b0}}, $unsigned(x_sq)};
                    fill_reg  <= fill_inc;
                    state_reg <= (fill_inc >= eff_len) ? ST_MUL_A : ST_IDLE;
                end
                ST_MUL_A: begin
                    prod_a_reg  <= prod_a_full[PROD_W-1:0];
                    neg_reg     <= sum_reg[SUM_W-1];
                    sum_abs_reg <= sum_reg[SUM_W-1] ? sum_neg[ABS_W-1:0]
                                                    : sum_reg[ABS_W-1:0];
                    state_reg   <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    prod_b_reg <= prod_b_full[PROD_W-1:0];
                    nn_reg     <= nn_full[NN_W-1:0];
                    state_reg  <= ST_SUB;
                end
                ST_SUB: begin
                    prod_a_reg <= prod_a_reg - prod_b_reg;
                    work_reg   <= {sum_abs_reg, {FRAC_BITS{1'b0}},
                                   {(WORK_W-MEAN_DIV_W){1'b0}}};
                    rem_reg    <= '0;
                    cnt_reg    <= '0;
                    state_reg  <= ST_DIV_MEAN;
                end
                ST_DIV_MEAN: begin
                    if (cnt_reg == MEAN_LAST) begin
                        mean_abs_reg <= work_shift[MEAN_DIV_W-1:0];
                        work_reg     <= {prod_a_reg, {FRAC_BITS{1'b0}},
                                         {(WORK_W-VAR_DIV_W){1'b0}}};
                        rem_reg      <= '0;
                        cnt_reg      <= '0;
                        state_reg    <= ST_DIV_VAR;
                    end else begin
                        rem_reg  <= step_rsp.rem;
                        cnt_reg  <= cnt_reg + CNT_W'(1);
                        work_reg <= work_shift;
                    end
                end
                ST_DIV_VAR: begin
                    if (cnt_reg == VAR_LAST) begin
                        var_reg   <= work_shift[VAR_W-1:0];
                        work_reg  <= {{(WORK_W-SQ_W-2*FRAC_BITS){1'b0}}, sumsq_reg,
                                      {(2*FRAC_BITS){1'b0}}};
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end else begin
                        rem_reg  <= step_rsp.rem;
                        cnt_reg  <= cnt_reg + CNT_W'(1);
                        work_reg <= work_shift;
                    end
                end
                ST_SQRT: begin
                    rem_reg  <= step_rsp.rem;
                    root_reg <= {root_reg[ROOT_W-2:0], step_rsp.qbit};
                    work_reg <= work_shift;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == SQRT_LAST) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_data_reg.mean_q8       <= mean_signed[MEAN_W-1:0];
                        m_data_reg.variance_q8   <= var_reg;
                        m_data_reg.energy        <= sumsq_reg[ENERGY_W-1:0];
                        m_data_reg.magnitude_q8  <= root_reg[MAG_W-1:0];
                        m_data_reg.window_number <= win_cnt_reg;
                        win_cnt_reg              <= win_cnt_reg + WIN_W'(1);
                        fill_reg                 <= '0;
                        sum_reg                  <= '0;
                        sumsq_reg                <= '0;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_W'(MAX_WINDOW))
        else $error("fill count beyond the largest window");

    a_accept_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_ACC))
        else $error("accepted word not accumulated");

    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && m_valid && !m_ready) |=> (state_reg == ST_FIN))
        else $error("result dropped while output register full");

    a_sqrt_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT && cnt_reg == SQRT_LAST) |=> (state_reg == ST_FIN))
        else $error("root iteration count wrong");
`endif

endmodule

`default_nettype wire
